@@ hw/rtl/prefix_code_table_decoder_assert.svh @@
// Assertion macros shared by the decoder checkers.
// Expects clk and rst_n in the scope of each use.
`ifndef PREFIX_CODE_TABLE_DECODER_ASSERT_SVH
`define PREFIX_CODE_TABLE_DECODER_ASSERT_SVH

// Same-cycle implication, off during reset.
`define PCTD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define PCTD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/pctd_pkg.sv @@
// Shared types, codes and constants for the prefix code table decoder.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package pctd_pkg;

    localparam int TABLE_DEPTH_DEF   = 256;
    localparam int MAX_CODE_BITS_DEF = 32;
    localparam int GRP_SIZE          = 16;
    localparam int QUEUE_DEPTH       = 2;

    localparam int CODE_W  = 32;
    localparam int LEN_W   = 6;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 9;
    localparam int ADDR_W  = 3;
    localparam int APB_W   = 32;
    localparam int IN_W    = 64;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_DATA    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    localparam logic REG_ENTRY_COUNT = 1'b0;
    localparam logic REG_LSB_FIRST   = 1'b1;

    localparam logic [COUNT_W-1:0] ENTRY_COUNT_RESET = 9'd1;
    localparam logic               LSB_FIRST_RESET   = 1'b1;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_DATA,
        CMD_RESTART
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [BYTE_W-1:0]  idx;
        logic [BYTE_W-1:0]  sym;
        logic [CODE_W-1:0]  code;
        logic [LEN_W-1:0]   len;
        logic [BYTE_W-1:0]  bits;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_GRP,
        ST_SEL,
        ST_DEC,
        ST_FLUSH
    } back_state_t;

    function automatic logic [BYTE_W-1:0] reverse8(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        for (int i = 0; i < BYTE_W; i++)
        begin
            r[i] = b[BYTE_W-1-i];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/pctd_front.sv @@
// Front end: accepts input items, drops unused ops, orders data bits.
// Depends on pctd_pkg; feeds pctd_queue.
`timescale 1ns / 1ps
`default_nettype none

module pctd_front (
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [pctd_pkg::IN_W-1:0] s_tdata,
    input  logic [1:0]               s_tuser,
    input  logic                     lsb_first,
    input  logic                     queue_full,
    output logic                     cmd_push,
    output pctd_pkg::cmd_t           cmd
);
    import pctd_pkg::*;

    logic keep;
    logic [BYTE_W-1:0] data_byte;

    assign s_tready  = !queue_full;
    assign data_byte = s_tdata[61:54];

    always_comb
    begin
        cmd.idx  = s_tdata[7:0];
        cmd.sym  = s_tdata[15:8];
        cmd.code = s_tdata[47:16];
        cmd.len  = s_tdata[53:48];
        // back end always takes bits from the top
        cmd.bits = lsb_first ? reverse8(data_byte) : data_byte;
        keep     = 1'b1;
        unique case (s_tuser)
            OP_LOAD:    cmd.kind = CMD_LOAD;
            OP_DATA:    cmd.kind = CMD_DATA;
            OP_RESTART: cmd.kind = CMD_RESTART;
            default:
            begin
                cmd.kind = CMD_LOAD;
                keep     = 1'b0;
            end
        endcase
    end

    assign cmd_push = s_tvalid && s_tready && keep;

endmodule

`default_nettype wire

@@ hw/rtl/pctd_queue.sv @@
// Short command queue between the front and back ends.
// Depends on pctd_pkg for the command type and depth.
`timescale 1ns / 1ps
`default_nettype none

module pctd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pctd_pkg::cmd_t din,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output pctd_pkg::cmd_t dout
);
    import pctd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t qmem [QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign do_push = push && !full;
    assign do_pop  = pop && valid;
    assign dout    = qmem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            qmem[wr_ptr_reg] <= din;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/pctd_back.sv @@
// Back end: code table, bit accumulator, parallel match and result output.
// Depends on pctd_pkg; takes commands from pctd_queue.
`timescale 1ns / 1ps
`default_nettype none

module pctd_back #(
    parameter int TABLE_DEPTH   = pctd_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_CODE_BITS = pctd_pkg::MAX_CODE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    input  pctd_pkg::cmd_t                cmd,
    output logic                          cmd_pop,
    input  logic [pctd_pkg::COUNT_W-1:0]  entry_count,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pctd_pkg::BYTE_W-1:0]   m_tdata,
    output logic [0:0]                    m_tuser,
    output logic                          m_tlast
);
    import pctd_pkg::*;

    localparam int AW    = MAX_CODE_BITS;
    localparam int CW    = $clog2(MAX_CODE_BITS + 1);
    localparam int LW    = (CW > LEN_W) ? CW : LEN_W;
    localparam int NGRP  = (TABLE_DEPTH + GRP_SIZE - 1) / GRP_SIZE;
    localparam int NPAD  = NGRP * GRP_SIZE;
    localparam int NPW   = $clog2(NPAD);
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int LOC_W = $clog2(GRP_SIZE);

    logic [CODE_W-1:0] code_tab_reg [TABLE_DEPTH];
    logic [LEN_W-1:0]  len_tab_reg  [TABLE_DEPTH];
    logic [BYTE_W-1:0] sym_mem      [TABLE_DEPTH];

    back_state_t       state_reg, state_next;
    logic [AW-1:0]     acc_reg, acc_next, acc_base;
    logic [CW-1:0]     cnt_reg, cnt_next, cnt_base;
    logic              halted_reg, halted_next;
    logic [BYTE_W-1:0] bits_reg, bits_next;
    logic [2:0]        bit_idx_reg, bit_idx_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [BYTE_W-1:0] pend_sym_reg, pend_sym_next;
    logic              pend_stop_reg, pend_stop_next;

    logic [NPAD-1:0]   match_reg, match_next;
    logic [NGRP-1:0]   grp_any_reg, grp_any_next;
    logic [LOC_W-1:0]  grp_loc_reg  [NGRP];
    logic [LOC_W-1:0]  grp_loc_next [NGRP];
    logic              hit_reg;
    logic [BYTE_W-1:0] sym_rd_reg;

    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_sym_reg;
    logic              out_stop_reg;
    logic              out_last_reg;

    logic [AW-1:0]     cnt_mask;
    logic              sel_hit;
    logic [NPW-1:0]    sel_idx;
    logic              tab_we, match_we, grp_we, sel_we;
    logic              emit, dec_stop, out_free;
    logic              push, push_stop, push_last;
    logic [BYTE_W-1:0] push_sym;

    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_sym_reg;
    assign m_tuser  = out_stop_reg;
    assign m_tlast  = out_last_reg;

    // compare every entry below entry_count against the accumulator and bit count
    assign cnt_mask = ~({AW{1'b1}} << cnt_reg);

    always_comb
    begin
        match_next = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            match_next[i] = (COUNT_W'(i) < entry_count)
                && (LW'(len_tab_reg[i]) == LW'(cnt_reg))
                && ((AW'(code_tab_reg[i]) & cnt_mask) == acc_reg);
        end
    end

    // first match within each group
    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_any_next[g] = |match_reg[g*GRP_SIZE +: GRP_SIZE];
            grp_loc_next[g] = '0;
            for (int k = GRP_SIZE - 1; k >= 0; k--)
            begin
                if (match_reg[g*GRP_SIZE + k])
                begin
                    grp_loc_next[g] = LOC_W'(k);
                end
            end
        end
    end

    // first group with a match
    always_comb
    begin
        sel_hit = 1'b0;
        sel_idx = '0;
        for (int g = NGRP - 1; g >= 0; g--)
        begin
            if (grp_any_reg[g])
            begin
                sel_hit = 1'b1;
                sel_idx = NPW'(g * GRP_SIZE) + NPW'(grp_loc_reg[g]);
            end
        end
    end

    assign dec_stop = !hit_reg && (cnt_reg >= CW'(MAX_CODE_BITS));
    assign emit     = hit_reg || dec_stop;
    assign acc_base = emit ? '0 : acc_reg;
    assign cnt_base = emit ? '0 : cnt_reg;

    always_comb
    begin
        state_next      = state_reg;
        acc_next        = acc_reg;
        cnt_next        = cnt_reg;
        halted_next     = halted_reg;
        bits_next       = bits_reg;
        bit_idx_next    = bit_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_sym_next   = pend_sym_reg;
        pend_stop_next  = pend_stop_reg;
        push            = 1'b0;
        push_sym        = pend_sym_reg;
        push_stop       = pend_stop_reg;
        push_last       = 1'b0;
        cmd_pop         = 1'b0;
        tab_we          = 1'b0;
        match_we        = 1'b0;
        grp_we          = 1'b0;
        sel_we          = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd.kind)
                        CMD_LOAD:
                        begin
                            tab_we = ({1'b0, cmd.idx} < COUNT_W'(TABLE_DEPTH));
                        end
                        CMD_RESTART:
                        begin
                            acc_next    = '0;
                            cnt_next    = '0;
                            halted_next = 1'b0;
                        end
                        CMD_DATA:
                        begin
                            if (!halted_reg)
                            begin
                                acc_next     = {acc_reg[AW-2:0], cmd.bits[BYTE_W-1]};
                                cnt_next     = cnt_reg + CW'(1);
                                bits_next    = {cmd.bits[BYTE_W-2:0], 1'b0};
                                bit_idx_next = '0;
                                state_next   = ST_CMP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_CMP:
            begin
                match_we   = 1'b1;
                state_next = ST_GRP;
            end
            ST_GRP:
            begin
                grp_we     = 1'b1;
                state_next = ST_SEL;
            end
            ST_SEL:
            begin
                sel_we     = 1'b1;
                state_next = ST_DEC;
            end
            ST_DEC:
            begin
                if (!(emit && pend_valid_reg && !out_free))
                begin
                    if (emit)
                    begin
                        push            = pend_valid_reg;
                        pend_valid_next = 1'b1;
                        pend_sym_next   = dec_stop ? '0 : sym_rd_reg;
                        pend_stop_next  = dec_stop;
                    end
                    if (dec_stop)
                    begin
                        halted_next = 1'b1;
                        acc_next    = '0;
                        cnt_next    = '0;
                        state_next  = ST_FLUSH;
                    end
                    else if (bit_idx_reg == 3'd7)
                    begin
                        acc_next   = acc_base;
                        cnt_next   = cnt_base;
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        acc_next     = {acc_base[AW-2:0], bits_reg[BYTE_W-1]};
                        cnt_next     = cnt_base + CW'(1);
                        bits_next    = {bits_reg[BYTE_W-2:0], 1'b0};
                        bit_idx_next = bit_idx_reg + 3'd1;
                        state_next   = ST_CMP;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    push            = 1'b1;
                    push_last       = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            acc_reg        <= '0;
            cnt_reg        <= '0;
            halted_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            acc_reg        <= acc_next;
            cnt_reg        <= cnt_next;
            halted_reg     <= halted_next;
            pend_valid_reg <= pend_valid_next;
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg      <= bits_next;
        bit_idx_reg   <= bit_idx_next;
        pend_sym_reg  <= pend_sym_next;
        pend_stop_reg <= pend_stop_next;
        if (push)
        begin
            out_sym_reg  <= push_sym;
            out_stop_reg <= push_stop;
            out_last_reg <= push_last;
        end
        if (match_we)
        begin
            match_reg <= match_next;
        end
        if (grp_we)
        begin
            grp_any_reg <= grp_any_next;
            grp_loc_reg <= grp_loc_next;
        end
        if (sel_we)
        begin
            hit_reg <= sel_hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tab_we)
        begin
            code_tab_reg[cmd.idx[IDX_W-1:0]] <= cmd.code;
            len_tab_reg[cmd.idx[IDX_W-1:0]]  <= cmd.len;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tab_we)
        begin
            sym_mem[cmd.idx[IDX_W-1:0]] <= cmd.sym;
        end
        if (sel_we)
        begin
            sym_rd_reg <= sym_mem[sel_idx[IDX_W-1:0]];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/prefix_code_table_decoder.sv @@
// A load or restart item is handled in the back end's idle step. A data byte
// goes bit by bit through compare, group pick, symbol read and decide, then a
// flush step, and no new item is taken before that; output back-pressure can
// hold decide and flush. A byte's last result leaves, marked last, in flush.
// Reset: rst_n asynchronous, active low; clears accumulator, halt and queue.
// Table entries are not cleared; registers reset to 1 entry, LSB first.
`timescale 1ns / 1ps
`default_nettype none

module prefix_code_table_decoder #(
    parameter int TABLE_DEPTH   = pctd_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_CODE_BITS = pctd_pkg::MAX_CODE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // entry_index[7:0], entry_symbol[15:8], entry_code[47:16],
    // entry_length[53:48], data_byte[61:54], zero[63:62]
    input  logic [pctd_pkg::IN_W-1:0]      s_tdata,
    // op[1:0]
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // symbol[7:0]
    output logic [pctd_pkg::BYTE_W-1:0]    m_tdata,
    // stop[0]
    output logic [0:0]                     m_tuser,
    output logic                           m_tlast,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pctd_pkg::ADDR_W-1:0]    paddr,
    input  logic [pctd_pkg::APB_W-1:0]     pwdata,
    output logic [pctd_pkg::APB_W-1:0]     prdata,
    output logic                           pready
);
    import pctd_pkg::*;

    logic [COUNT_W-1:0] entry_count_reg;
    logic               lsb_first_reg;
    logic               cfg_we;
    logic               queue_full, queue_valid, cmd_push, cmd_pop;
    cmd_t               front_cmd, queue_cmd;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= ENTRY_COUNT_RESET;
            lsb_first_reg   <= LSB_FIRST_RESET;
        end
        else if (cfg_we)
        begin
            unique case (paddr[2])
                REG_ENTRY_COUNT: entry_count_reg <= pwdata[COUNT_W-1:0];
                REG_LSB_FIRST:   lsb_first_reg   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_ENTRY_COUNT: prdata = APB_W'(entry_count_reg);
            REG_LSB_FIRST:   prdata = APB_W'(lsb_first_reg);
            default:         prdata = '0;
        endcase
    end

    pctd_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .lsb_first  (lsb_first_reg),
        .queue_full (queue_full),
        .cmd_push   (cmd_push),
        .cmd        (front_cmd)
    );

    pctd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .din   (front_cmd),
        .full  (queue_full),
        .pop   (cmd_pop),
        .valid (queue_valid),
        .dout  (queue_cmd)
    );

    pctd_back #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (queue_valid),
        .cmd         (queue_cmd),
        .cmd_pop     (cmd_pop),
        .entry_count (entry_count_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

`default_nettype wire

@@ hw/rtl/pctd_checker.sv @@
// Port-level checker for the decoder output stream, bound to the top level.
// Depends on prefix_code_table_decoder_assert.svh and pctd_pkg.
`timescale 1ns / 1ps
`default_nettype none

`include "prefix_code_table_decoder_assert.svh"

module pctd_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [pctd_pkg::BYTE_W-1:0]  m_tdata,
    input logic [0:0]                   m_tuser,
    input logic                         m_tlast
);
    import pctd_pkg::*;

    `PCTD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "output item changed while stalled")
    `PCTD_ASSERT_NOW(a_stop_zero, m_tvalid && m_tuser[0], m_tdata == '0, "stop item carries a nonzero symbol")
    `PCTD_ASSERT_NOW(a_stop_last, m_tvalid && m_tuser[0], m_tlast, "stop item is not the last of its byte")

endmodule

bind prefix_code_table_decoder pctd_checker u_pctd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
